// ===== hw/rtl/fsl_pkg.sv =====
// ----------------------------------------------------------------------------
// fsl_pkg: shared definitions for the four-channel slew limiter
// Command codes, register indexes, reset values and lane interface types.
// ----------------------------------------------------------------------------
package fsl_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int NUM_FIELDS   = 4;   // channels that have input and output fields
	localparam int LEVEL_W      = 8;
	localparam int LIMIT_W      = 7;
	localparam int CFG_DATA_W   = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int CMD_W        = 2;

	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_REQ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INSTANT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_UP    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DOWN  = 2'd3;

	localparam logic [LIMIT_W-1:0]        RST_STEP_SIZE = 7'd5;
	localparam logic [LIMIT_W-1:0]        RST_MAX_LEVEL = 7'd100;
	localparam logic [LIMIT_W-1:0]        RST_MIN_UP    = 7'd0;
	localparam logic signed [LEVEL_W-1:0] RST_MIN_DOWN  = 8'sd0;

	localparam logic KIND_RAMP    = 1'b0;
	localparam logic KIND_INSTANT = 1'b1;

	typedef struct packed {
		logic [LIMIT_W-1:0]        step_size;
		logic [LIMIT_W-1:0]        max_level;
		logic [LIMIT_W-1:0]        min_up_level;
		logic signed [LEVEL_W-1:0] min_down_level;
	} fsl_cfg_t;

	typedef struct packed {
		logic tick;
		logic set_req;
		logic instant;
	} fsl_ctrl_t;

endpackage

// ===== hw/rtl/fsl_lane.sv =====
// ----------------------------------------------------------------------------
// fsl_lane: one slew-limited drive channel
// Holds the requested and current level of one channel and works out the
// next current level for a tick, a request update or an instant set.
// ----------------------------------------------------------------------------
module fsl_lane
	import fsl_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  fsl_cfg_t                  cfg,
	input  fsl_ctrl_t                 ctrl,
	input  logic signed [LEVEL_W-1:0] req_value,
	input  logic signed [LEVEL_W-1:0] instant_value,
	output logic signed [LEVEL_W-1:0] level_next
);

	// Wide enough for a level plus or minus the largest step.
	localparam int WIDE_W = LEVEL_W + 2;

	logic signed [LEVEL_W-1:0] target_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic signed [WIDE_W-1:0]  cur_w;
	logic signed [WIDE_W-1:0]  tgt_w;
	logic signed [WIDE_W-1:0]  step_w;
	logic signed [WIDE_W-1:0]  max_w;
	logic signed [WIDE_W-1:0]  min_up_w;
	logic signed [WIDE_W-1:0]  min_down_w;
	logic signed [WIDE_W-1:0]  moved;
	logic signed [WIDE_W-1:0]  clamped;
	logic signed [WIDE_W-1:0]  pushed;

	always_comb begin
		cur_w      = WIDE_W'(level_q);
		tgt_w      = WIDE_W'(target_q);
		step_w     = signed'({{(WIDE_W-LIMIT_W){1'b0}}, cfg.step_size});
		max_w      = signed'({{(WIDE_W-LIMIT_W){1'b0}}, cfg.max_level});
		min_up_w   = signed'({{(WIDE_W-LIMIT_W){1'b0}}, cfg.min_up_level});
		min_down_w = WIDE_W'(cfg.min_down_level);

		// The full step is taken even when it passes the target.
		if (tgt_w > cur_w) begin
			moved = cur_w + step_w;
		end else if (tgt_w < cur_w) begin
			moved = cur_w - step_w;
		end else begin
			moved = cur_w;
		end

		clamped = moved;
		if (clamped > max_w) begin
			clamped = max_w;
		end
		if (clamped < -max_w) begin
			clamped = -max_w;
		end

		// The minimum zone is applied after the clamp, so it wins over max_level.
		pushed = clamped;
		if (pushed > 0 && pushed < min_up_w) begin
			pushed = min_up_w;
		end
		if (pushed < 0 && pushed > min_down_w) begin
			pushed = min_down_w;
		end

		if (ctrl.instant) begin
			level_next = instant_value;
		end else if (ctrl.tick) begin
			level_next = pushed[LEVEL_W-1:0];
		end else begin
			level_next = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			level_q  <= '0;
		end else begin
			if (ctrl.set_req) begin
				target_q <= req_value;
			end else if (ctrl.instant) begin
				target_q <= instant_value;
			end
			if (ctrl.tick || ctrl.instant) begin
				level_q <= level_next;
			end
		end
	end

endmodule

// ===== hw/rtl/four_channel_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// four_channel_slew_limiter: ramped drive levels for four motor channels
// Command beats update the channel lanes; result beats carry all four levels.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one command beat. A tick
//   moves every channel one step toward its request and returns one result
//   beat; a set-request beat stores four requests and returns nothing; an
//   instant beat sets left and right sides directly and returns one beat.
//   Command code 3 is taken and ignored.
//   The output channel (out_valid/out_ready) carries drive_kind and the four
//   levels. A result appears in the cycle after its command beat is taken.
//   Throughput is one beat per cycle: each lane does its add, clamp and
//   minimum-zone push combinationally and the result lands in one output
//   register. in_ready is high while that register is empty or being taken,
//   so a stalled receiver holds its result and blocks the input only then.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and belong to idle periods.
//   Reset clears all requests and levels to zero, loads the default limits
//   and empties the output register.
// ----------------------------------------------------------------------------
module four_channel_slew_limiter
	import fsl_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [CMD_W-1:0]             cmd,
	input  logic signed [LEVEL_W-1:0]    lf_target,
	input  logic signed [LEVEL_W-1:0]    lb_target,
	input  logic signed [LEVEL_W-1:0]    rf_target,
	input  logic signed [LEVEL_W-1:0]    rb_target,
	input  logic signed [LEVEL_W-1:0]    left_power,
	input  logic signed [LEVEL_W-1:0]    right_power,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         drive_kind,
	output logic signed [LEVEL_W-1:0]    lf_drive,
	output logic signed [LEVEL_W-1:0]    lb_drive,
	output logic signed [LEVEL_W-1:0]    rf_drive,
	output logic signed [LEVEL_W-1:0]    rb_drive
);

	fsl_cfg_t                  cfg_q;
	fsl_ctrl_t                 ctrl;
	logic                      accept;
	logic                      has_result;
	logic signed [LEVEL_W-1:0] req_field [NUM_FIELDS];
	logic signed [LEVEL_W-1:0] pow_field [NUM_FIELDS];
	logic signed [LEVEL_W-1:0] lane_next [NUM_CHANNELS];
	logic signed [LEVEL_W-1:0] merged    [NUM_FIELDS];
	logic                      valid_q;
	logic                      kind_q;
	logic signed [LEVEL_W-1:0] drive_q   [NUM_FIELDS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_size      <= RST_STEP_SIZE;
			cfg_q.max_level      <= RST_MAX_LEVEL;
			cfg_q.min_up_level   <= RST_MIN_UP;
			cfg_q.min_down_level <= RST_MIN_DOWN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STEP_SIZE: cfg_q.step_size      <= cfg_data[LIMIT_W-1:0];
				REG_MAX_LEVEL: cfg_q.max_level      <= cfg_data[LIMIT_W-1:0];
				REG_MIN_UP:    cfg_q.min_up_level   <= cfg_data[LIMIT_W-1:0];
				REG_MIN_DOWN:  cfg_q.min_down_level <= signed'(cfg_data);
				default:       ;
			endcase
		end
	end

	assign in_ready = !valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ctrl.tick    = accept && (cmd == CMD_TICK);
		ctrl.set_req = accept && (cmd == CMD_SET_REQ);
		ctrl.instant = accept && (cmd == CMD_INSTANT);
		has_result   = ctrl.tick || ctrl.instant;
	end

	assign req_field[0] = lf_target;
	assign req_field[1] = lb_target;
	assign req_field[2] = rf_target;
	assign req_field[3] = rb_target;
	assign pow_field[0] = left_power;
	assign pow_field[1] = left_power;
	assign pow_field[2] = right_power;
	assign pow_field[3] = right_power;

	for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_lane
		logic signed [LEVEL_W-1:0] lane_req;
		logic signed [LEVEL_W-1:0] lane_pow;

		// Lanes beyond the input fields are set to zero by both set commands.
		if (i < NUM_FIELDS) begin : g_fed
			assign lane_req = req_field[i];
			assign lane_pow = pow_field[i];
		end else begin : g_unfed
			assign lane_req = '0;
			assign lane_pow = '0;
		end

		fsl_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.cfg           (cfg_q),
			.ctrl          (ctrl),
			.req_value     (lane_req),
			.instant_value (lane_pow),
			.level_next    (lane_next[i])
		);
	end

	// Output fields of absent channels read as zero.
	for (genvar j = 0; j < NUM_FIELDS; j++) begin : g_merge
		if (j < NUM_CHANNELS) begin : g_present
			assign merged[j] = lane_next[j];
		end else begin : g_absent
			assign merged[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (has_result) begin
			kind_q  <= ctrl.instant ? KIND_INSTANT : KIND_RAMP;
			drive_q <= merged;
		end
	end

	assign out_valid  = valid_q;
	assign drive_kind = kind_q;
	assign lf_drive   = drive_q[0];
	assign lb_drive   = drive_q[1];
	assign rf_drive   = drive_q[2];
	assign rb_drive   = drive_q[3];

endmodule
